FILE: rtl/pfed_pkg.sv
// ============================================================================
// pfed_pkg
// Shared types, codes and the fault pattern table of the PMIC fault pattern
// event detector.
// ============================================================================
package pfed_pkg;

    localparam int NUM_MODULES     = 6;
    localparam int NUM_FAULT_TYPES = 17;
    localparam int TABLE_ROWS      = 17;
    localparam int PAT_LEN         = 6;
    localparam int MOD_W           = 3;
    localparam int FT_W            = 5;
    localparam int LEN_W           = 8;
    localparam int REC_W           = 80;
    localparam int MOD_IDX_W       = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

    // Queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_COMPARE  = 1'b0;
    localparam logic OP_SET_FLAG = 1'b1;

    localparam logic [1:0] PATH_ENGINE = 2'd0;
    localparam logic [1:0] PATH_DIRECT = 2'd1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MODULE = 2'd1,
        ST_BAD_TYPE   = 2'd2,
        ST_BAD_PATH   = 2'd3
    } status_t;

    // One accepted item as the back end sees it: the events still to be
    // reported, in rising fault-type order, and the closing status.
    typedef struct packed {
        logic [NUM_FAULT_TYPES-1:0] events;
        logic [MOD_W-1:0]           mod_idx;
        status_t                    status;
    } pfed_cmd_t;

    localparam logic [3:0] POS_ENGINE [PAT_LEN] = '{4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9};
    localparam logic [3:0] POS_DIRECT [PAT_LEN] = '{4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6};

    localparam logic [7:0] MASKS [TABLE_ROWS][PAT_LEN] = '{
        '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00},
        '{8'h02, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h10, 8'h02, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h80, 8'h02, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h20, 8'h02, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h0F, 8'h02, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hF0},
        '{8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00}
    };

endpackage

FILE: rtl/pfed_front.sv
// ============================================================================
// pfed_front
// Accepts items, matches the record against the pattern table, keeps the
// per-module fault flags and hands a command to the queue.
// ============================================================================
module pfed_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic                         in_op,
    input  logic [pfed_pkg::MOD_W-1:0]   in_mod,
    input  logic [1:0]                   in_path,
    input  logic [pfed_pkg::LEN_W-1:0]   in_len,
    input  logic [pfed_pkg::REC_W-1:0]   in_rec,
    input  logic [pfed_pkg::FT_W-1:0]    in_ftype,
    input  logic                         q_full,
    output logic                         push,
    output pfed_pkg::pfed_cmd_t          push_cmd
);

    logic [pfed_pkg::NUM_FAULT_TYPES-1:0] flags_reg [pfed_pkg::NUM_MODULES];
    logic [pfed_pkg::NUM_FAULT_TYPES-1:0] flags_next;
    logic [pfed_pkg::NUM_FAULT_TYPES-1:0] cur_flags;
    logic [pfed_pkg::NUM_FAULT_TYPES-1:0] hit;
    logic [pfed_pkg::NUM_FAULT_TYPES-1:0] type_bit;
    logic [7:0]                           sel_byte [pfed_pkg::PAT_LEN];
    logic [3:0]                           pos;
    logic [pfed_pkg::MOD_IDX_W-1:0]       idx;
    logic                                 mod_ok;
    logic                                 ftype_ok;
    logic                                 len_ok;
    logic                                 row_ok;
    logic                                 write_flags;

    assign push = in_valid && !q_full;
    assign idx  = in_mod[pfed_pkg::MOD_IDX_W-1:0];

    always_comb begin
        mod_ok    = ({1'b0, in_mod} < 4'(pfed_pkg::NUM_MODULES));
        ftype_ok  = ({1'b0, in_ftype} < 6'(pfed_pkg::NUM_FAULT_TYPES));
        cur_flags = mod_ok ? flags_reg[idx] : '0;

        // Pick the six bytes of the chosen layout; every one of them must lie
        // inside the record, whatever the masks ask for.
        len_ok = 1'b1;
        for (int r = 0; r < pfed_pkg::PAT_LEN; r++) begin
            pos = (in_path == pfed_pkg::PATH_DIRECT) ? pfed_pkg::POS_DIRECT[r]
                                                     : pfed_pkg::POS_ENGINE[r];
            sel_byte[r] = in_rec[8 * pos +: 8];
            if ({4'd0, pos} >= in_len) begin
                len_ok = 1'b0;
            end
        end

        for (int t = 0; t < pfed_pkg::NUM_FAULT_TYPES; t++) begin
            row_ok = len_ok;
            for (int r = 0; r < pfed_pkg::PAT_LEN; r++) begin
                if ((sel_byte[r] & pfed_pkg::MASKS[t][r]) != pfed_pkg::MASKS[t][r]) begin
                    row_ok = 1'b0;
                end
            end
            hit[t]      = row_ok;
            type_bit[t] = (in_ftype == 5'(t));
        end

        push_cmd.mod_idx = in_mod;
        push_cmd.events  = '0;
        write_flags      = 1'b0;
        flags_next       = cur_flags;
        priority if (!mod_ok) begin
            push_cmd.status = pfed_pkg::ST_BAD_MODULE;
        end else if (in_op == pfed_pkg::OP_SET_FLAG) begin
            if (ftype_ok) begin
                push_cmd.status = pfed_pkg::ST_OK;
                write_flags     = 1'b1;
                flags_next      = cur_flags | type_bit;
            end else begin
                push_cmd.status = pfed_pkg::ST_BAD_TYPE;
            end
        end else if (in_path != pfed_pkg::PATH_ENGINE && in_path != pfed_pkg::PATH_DIRECT) begin
            push_cmd.status = pfed_pkg::ST_BAD_PATH;
        end else begin
            // Matching patterns end up set, the others cleared; only the ones
            // that were clear before are reported.
            push_cmd.status = pfed_pkg::ST_OK;
            push_cmd.events = hit & ~cur_flags;
            write_flags     = 1'b1;
            flags_next      = hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < pfed_pkg::NUM_MODULES; m++) begin
                flags_reg[m] <= '0;
            end
        end else if (push && write_flags) begin
            flags_reg[idx] <= flags_next;
        end
    end

endmodule

FILE: rtl/pfed_queue.sv
// ============================================================================
// pfed_queue
// Short command queue that decouples the front end from the result
// sequencer.
// ============================================================================
module pfed_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pfed_pkg::pfed_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output pfed_pkg::pfed_cmd_t head_cmd
);

    pfed_pkg::pfed_cmd_t              mem_reg [pfed_pkg::QUEUE_DEPTH];
    logic [pfed_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [pfed_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [pfed_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [pfed_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [pfed_pkg::QCNT_W-1:0]      count_reg;
    logic [pfed_pkg::QCNT_W-1:0]      count_next;

    assign full       = (count_reg == pfed_pkg::QCNT_W'(pfed_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/pfed_back.sv
// ============================================================================
// pfed_back
// Result sequencer: reports the pending events of one command, lowest fault
// type first, one per cycle unless stalled, then the closing status item.
// ============================================================================
module pfed_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  pfed_pkg::pfed_cmd_t head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_is_event,
    output logic [2:0]          out_mod,
    output logic [4:0]          out_ftype,
    output logic [1:0]          out_status,
    output logic                out_last
);

    pfed_pkg::pfed_cmd_t cmd_reg;
    pfed_pkg::pfed_cmd_t cmd_next;
    logic                busy_reg;
    logic                busy_next;
    logic [4:0]          low_idx;
    logic                take;

    always_comb begin
        low_idx = '0;
        for (int t = pfed_pkg::NUM_FAULT_TYPES - 1; t >= 0; t--) begin
            if (cmd_reg.events[t]) begin
                low_idx = 5'(t);
            end
        end

        out_valid    = busy_reg;
        out_is_event = |cmd_reg.events;
        out_last     = !out_is_event;
        out_mod      = out_is_event ? cmd_reg.mod_idx : '0;
        out_ftype    = out_is_event ? low_idx : '0;
        out_status   = out_is_event ? 2'(pfed_pkg::ST_OK) : 2'(cmd_reg.status);

        // The next command is loaded in the cycle its predecessor's status
        // item leaves, so there is no gap between items when one is queued.
        take      = !busy_reg || (out_ready && out_last);
        pop       = take && head_valid;
        busy_next = busy_reg;
        cmd_next  = cmd_reg;
        if (take) begin
            busy_next = head_valid;
            cmd_next  = head_cmd;
        end else if (out_ready) begin
            cmd_next.events = cmd_reg.events & (cmd_reg.events - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

FILE: rtl/pmic_fault_pattern_event_detector_unit.sv
// ============================================================================
// pmic_fault_pattern_event_detector_unit
// Matches power-IC error-log records against the fault pattern table and
// reports newly raised faults per memory module.
// ============================================================================
// An item is accepted whenever the four-entry command queue has room; the
// match and the fault flag update are done at acceptance. Each item then
// yields N event items plus one status item (1 to 18 items in all),
// delivered by the result sequencer one per cycle while m_tready is high.
// The fault flags are cleared by reset at once; no sweep is needed.
module pmic_fault_pattern_event_detector_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // module_index[2:0], path_select[4:3], record_length[12:5],
    // record_bytes_low[76:13], record_bytes_high[92:77], fault_type_in[97:93]
    input  logic [103:0] s_tdata,
    // operation[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_module[2:0], event_fault_type[7:3], status[9:8]
    output logic [15:0]  m_tdata,
    // is_event[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    pfed_pkg::pfed_cmd_t push_cmd;
    pfed_pkg::pfed_cmd_t head_cmd;
    logic                push;
    logic                q_full;
    logic                pop;
    logic                head_valid;
    logic [2:0]          out_mod;
    logic [4:0]          out_ftype;
    logic [1:0]          out_status;

    assign s_tready = !q_full;
    assign m_tdata  = {6'd0, out_status, out_ftype, out_mod};

    pfed_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_mod   (s_tdata[2:0]),
        .in_path  (s_tdata[4:3]),
        .in_len   (s_tdata[12:5]),
        .in_rec   (s_tdata[92:13]),
        .in_ftype (s_tdata[97:93]),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    pfed_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    pfed_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_is_event (m_tuser[0]),
        .out_mod      (out_mod),
        .out_ftype    (out_ftype),
        .out_status   (out_status),
        .out_last     (m_tlast)
    );

endmodule

FILE: verif/pmic_fault_pattern_event_detector_unit_test.sv
// ============================================================================
// pmic_fault_pattern_event_detector_unit_test
// Self-checking testbench for the PMIC fault pattern event detector. Error
// records and direct flag writes are streamed in. A predictor keeps its own
// copy of the per-module fault flags and works out the expected event and
// status items. Every result item is checked field by field, in order.
// ============================================================================
module pmic_fault_pattern_event_detector_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] PATH_SPARE_A = 2'd2;
    localparam logic [1:0] PATH_SPARE_B = 2'd3;
    localparam logic [79:0] REC_ONES    = '1;
    localparam int DRAIN_CYCLES         = 40;

    // Byte positions and bit masks of the fault pattern table.
    localparam logic [3:0] ENGINE_POS [6] = '{4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9};
    localparam logic [3:0] DIRECT_POS [6] = '{4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6};
    localparam logic [7:0] FAULT_MASK [17][6] = '{
        '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00},
        '{8'h02, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h10, 8'h02, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h80, 8'h02, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h20, 8'h02, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h0F, 8'h02, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hF0},
        '{8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00}
    };

    typedef struct {
        logic        op;
        logic [2:0]  mod_no;
        logic [1:0]  path;
        logic [7:0]  len;
        logic [79:0] rec;
        logic [4:0]  ftype;
    } log_record_t;

    typedef struct {
        logic              is_event;
        logic [2:0]        mod_no;
        logic [4:0]        ftype;
        pfed_pkg::status_t status;
        logic              last;
    } fault_report_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    log_record_t   pending_records[$];
    fault_report_t expected_reports[$];
    logic [pfed_pkg::NUM_FAULT_TYPES-1:0] flag_model [pfed_pkg::NUM_MODULES];

    int n_presented = 0;
    int n_accepted  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches  = 0;
    int n_compare   = 0;
    int n_setflag   = 0;
    int n_events    = 0;
    int n_errstatus = 0;

    pmic_fault_pattern_event_detector_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void push_report(logic is_event, logic [2:0] mod_no,
                                        logic [4:0] ftype, pfed_pkg::status_t status);
        fault_report_t r;
        r.is_event = is_event;
        r.mod_no   = mod_no;
        r.ftype    = ftype;
        r.status   = status;
        r.last     = !is_event;
        expected_reports.push_back(r);
    endfunction

    // Applies one accepted record to the flag copy and queues the items it
    // should produce: new events in rising fault-type order, then the status.
    function automatic void match_fault_patterns(log_record_t it);
        logic [3:0] pos [6];
        logic [7:0] m;
        bit         hit;
        if (it.mod_no >= pfed_pkg::NUM_MODULES) begin
            push_report(1'b0, '0, '0, pfed_pkg::ST_BAD_MODULE);
            return;
        end
        if (it.op == pfed_pkg::OP_SET_FLAG) begin
            if (it.ftype >= pfed_pkg::NUM_FAULT_TYPES) begin
                push_report(1'b0, '0, '0, pfed_pkg::ST_BAD_TYPE);
                return;
            end
            flag_model[it.mod_no][it.ftype] = 1'b1;
            push_report(1'b0, '0, '0, pfed_pkg::ST_OK);
            return;
        end
        if (it.path != pfed_pkg::PATH_ENGINE && it.path != pfed_pkg::PATH_DIRECT) begin
            push_report(1'b0, '0, '0, pfed_pkg::ST_BAD_PATH);
            return;
        end
        for (int r = 0; r < 6; r++) begin
            pos[r] = (it.path == pfed_pkg::PATH_ENGINE) ? ENGINE_POS[r] : DIRECT_POS[r];
        end
        for (int t = 0; t < pfed_pkg::NUM_FAULT_TYPES; t++) begin
            hit = 1'b1;
            for (int r = 0; r < 6; r++) begin
                m = FAULT_MASK[t][r];
                if (pos[r] >= it.len || (it.rec[8*pos[r] +: 8] & m) != m) begin
                    hit = 1'b0;
                end
            end
            if (!hit) begin
                flag_model[it.mod_no][t] = 1'b0;
            end else if (!flag_model[it.mod_no][t]) begin
                flag_model[it.mod_no][t] = 1'b1;
                push_report(1'b1, it.mod_no, 5'(t), pfed_pkg::ST_OK);
            end
        end
        push_report(1'b0, '0, '0, pfed_pkg::ST_OK);
    endfunction

    function automatic void queue_record(logic op, logic [2:0] mod_no, logic [1:0] path,
                                         logic [7:0] len, logic [79:0] rec,
                                         logic [4:0] ftype);
        log_record_t it;
        it.op     = op;
        it.mod_no = mod_no;
        it.path   = path;
        it.len    = len;
        it.rec    = rec;
        it.ftype  = ftype;
        pending_records.push_back(it);
    endfunction

    // Mostly well-formed compare records built from a few table patterns on
    // top of sparse or random noise; the rest are flag writes and bad codes.
    function automatic log_record_t random_record();
        log_record_t it;
        logic [79:0] noise;
        logic [3:0]  p;
        int          n_pat;
        int          t;
        it.op     = ($urandom_range(99) < 12) ? pfed_pkg::OP_SET_FLAG : pfed_pkg::OP_COMPARE;
        it.mod_no = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 6))
                                             : 3'($urandom_range(pfed_pkg::NUM_MODULES - 1));
        it.path   = ($urandom_range(99) < 8) ? 2'($urandom_range(3, 2))
                                             : 2'($urandom_range(1));
        it.len    = ($urandom_range(99) < 15) ? 8'($urandom_range(9))
                                              : 8'($urandom_range(255, 10));
        it.ftype  = ($urandom_range(1) == 0) ? 5'($urandom_range(31))
                                             : 5'($urandom_range(pfed_pkg::NUM_FAULT_TYPES - 1));
        noise = 80'({$urandom, $urandom, $urandom});
        if ($urandom_range(99) < 70) begin
            noise = noise & 80'({$urandom, $urandom, $urandom})
                          & 80'({$urandom, $urandom, $urandom});
        end
        n_pat = $urandom_range(4);
        for (int k = 0; k < n_pat; k++) begin
            t = $urandom_range(pfed_pkg::NUM_FAULT_TYPES - 1);
            for (int r = 0; r < 6; r++) begin
                p = (it.path == pfed_pkg::PATH_DIRECT) ? DIRECT_POS[r] : ENGINE_POS[r];
                noise[8*p +: 8] = noise[8*p +: 8] | FAULT_MASK[t][r];
            end
        end
        it.rec = noise;
        return it;
    endfunction

    // Driver: a new item is offered only once the previous one has gone.
    always @(negedge aclk) begin
        log_record_t it;
        if (aresetn) begin
            if (!s_tvalid || n_accepted == n_presented) begin
                if (pending_records.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    it = pending_records.pop_front();
                    s_tdata  <= {6'd0, it.ftype, it.rec[79:64], it.rec[63:0], it.len,
                                 it.path, it.mod_no};
                    s_tuser  <= it.op;
                    s_tvalid <= 1'b1;
                    n_presented = n_presented + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Input acceptance is handled before the output check so that a result
    // on the same edge always finds its expectation queued.
    always @(posedge aclk) begin
        log_record_t   it;
        fault_report_t exp_r;
        fault_report_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                it.op     = s_tuser[0];
                it.mod_no = s_tdata[2:0];
                it.path   = s_tdata[4:3];
                it.len    = s_tdata[12:5];
                it.rec    = {s_tdata[92:77], s_tdata[76:13]};
                it.ftype  = s_tdata[97:93];
                if (it.op == pfed_pkg::OP_SET_FLAG) n_setflag++;
                else n_compare++;
                match_fault_patterns(it);
                n_accepted <= n_accepted + 1;
            end
            if (m_tvalid && m_tready) begin
                got.is_event = m_tuser[0];
                got.mod_no   = m_tdata[2:0];
                got.ftype    = m_tdata[7:3];
                got.status   = pfed_pkg::status_t'(m_tdata[9:8]);
                got.last     = m_tlast;
                if (got.is_event) n_events++;
                else if (got.status != pfed_pkg::ST_OK) n_errstatus++;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item: event=%0b module=%0d type=%0d %s",
                                 got.is_event, got.mod_no, got.ftype, got.status.name());
                end else begin
                    exp_r = expected_reports.pop_front();
                    if (got.is_event !== exp_r.is_event || got.mod_no !== exp_r.mod_no ||
                        got.ftype !== exp_r.ftype || got.status !== exp_r.status ||
                        got.last !== exp_r.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch at %0t:", $realtime);
                            $display("  expected event=%0b module=%0d type=%0d status=%0d last=%0b",
                                     exp_r.is_event, exp_r.mod_no, exp_r.ftype,
                                     exp_r.status, exp_r.last);
                            $display("  got      event=%0b module=%0d type=%0d status=%0d last=%0b",
                                     got.is_event, got.mod_no, got.ftype,
                                     got.status, got.last);
                        end
                    end
                end
            end
        end
    end

    task automatic drain();
        while (pending_records.size() > 0 || n_accepted != n_presented ||
               expected_reports.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < pfed_pkg::NUM_MODULES; i++) flag_model[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 57;
        // Every pattern, then repeat suppression, then clearing by length.
        queue_record(pfed_pkg::OP_COMPARE, 3'd0, pfed_pkg::PATH_ENGINE, 8'd10, '0, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd0, pfed_pkg::PATH_ENGINE, 8'd10, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd0, pfed_pkg::PATH_ENGINE, 8'd10, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd0, pfed_pkg::PATH_ENGINE, 8'd9, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd0, pfed_pkg::PATH_ENGINE, 8'd255,
                     REC_ONES, 5'd31);
        queue_record(pfed_pkg::OP_COMPARE, 3'd5, pfed_pkg::PATH_DIRECT, 8'd7, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd5, pfed_pkg::PATH_DIRECT, 8'd6, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd5, pfed_pkg::PATH_DIRECT, 8'd0, REC_ONES, 5'd0);
        // Flags set directly hold back their events on the next compare.
        queue_record(pfed_pkg::OP_SET_FLAG, 3'd1, pfed_pkg::PATH_ENGINE, 8'd0, '0, 5'd0);
        queue_record(pfed_pkg::OP_SET_FLAG, 3'd1, pfed_pkg::PATH_ENGINE, 8'd0, '0, 5'd16);
        queue_record(pfed_pkg::OP_SET_FLAG, 3'd1, pfed_pkg::PATH_ENGINE, 8'd0, '0, 5'd17);
        queue_record(pfed_pkg::OP_SET_FLAG, 3'd1, pfed_pkg::PATH_ENGINE, 8'd0, '0, 5'd31);
        queue_record(pfed_pkg::OP_COMPARE, 3'd1, pfed_pkg::PATH_ENGINE, 8'd10,
                     REC_ONES, 5'd31);
        // Module range is tested first, before the path or the type.
        queue_record(pfed_pkg::OP_COMPARE, 3'd6, pfed_pkg::PATH_ENGINE, 8'd10, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_SET_FLAG, 3'd7, pfed_pkg::PATH_ENGINE, 8'd0, '0, 5'd3);
        queue_record(pfed_pkg::OP_COMPARE, 3'd7, PATH_SPARE_B, 8'd10, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd2, PATH_SPARE_A, 8'd10, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd2, PATH_SPARE_B, 8'd10, REC_ONES, 5'd0);
        queue_record(pfed_pkg::OP_SET_FLAG, 3'd0, PATH_SPARE_B, 8'd255, REC_ONES, 5'd5);
        // Sparse records: one matches a single pattern, one matches four, one none.
        queue_record(pfed_pkg::OP_COMPARE, 3'd3, pfed_pkg::PATH_ENGINE, 8'd10,
                     80'h04 << 24, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd3, pfed_pkg::PATH_ENGINE, 8'd10,
                     80'h0F02 << 24, 5'd0);
        queue_record(pfed_pkg::OP_COMPARE, 3'd4, pfed_pkg::PATH_DIRECT, 8'd200,
                     80'h40_0000_0000, 5'd0);
        for (int i = 0; i < 60; i++) pending_records.push_back(random_record());
        drain();

        tx_idle_pct = 57;
        rx_idle_pct = 8;
        for (int i = 0; i < 90; i++) pending_records.push_back(random_record());
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 90; i++) pending_records.push_back(random_record());
        drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Streamed %0d compare records and %0d direct flag writes.",
                 n_compare, n_setflag);
        $display("Saw %0d fault events and %0d error statuses; %0d mismatches.",
                 n_events, n_errstatus, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
